// ----- design/depq_pkg.sv -----
// Shared constants, command and status codes, and control structs for the queue.
`timescale 1ns / 1ps
`default_nettype none

package depq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CMD_W         = 2;
  localparam int ID_W          = 16;
  localparam int PRI_W         = 32;
  localparam int STATUS_W      = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_HIGH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_LOW  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic latch_req;
    logic do_insert;
    logic set_ok;
    logic set_full;
    logic set_empty;
    logic scan_init;
    logic scan_rd;
    logic scan_cmp;
    logic shift_rd;
    logic shift_wr;
    logic pop_finish;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_pop;
    logic is_empty;
    logic is_full;
    logic scan_last;
    logic shift_more;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/depq_if.sv -----
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps
`default_nettype none

interface depq_req_if;
  logic                      valid;
  logic                      ready;
  logic [depq_pkg::CMD_W-1:0] command;
  logic [depq_pkg::ID_W-1:0]  client_id;
  logic [depq_pkg::PRI_W-1:0] priority_req;

  modport source (output valid, output command, output client_id, output priority_req,
                  input ready);
  modport sink (input valid, input command, input client_id, input priority_req,
                output ready);
endinterface

interface depq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [depq_pkg::STATUS_W-1:0] status;
  logic [depq_pkg::ID_W-1:0]     served_id;

  modport source (output valid, output status, output served_id, input ready);
  modport sink (input valid, input status, input served_id, output ready);
endinterface

`default_nettype wire

// ----- design/double_ended_priority_queue_top.sv -----
// Top level of the double-ended priority queue.
`timescale 1ns / 1ps
`default_nettype none

// Stores up to DEPTH (id, priority) entries in insertion order in a single-port
// read, single-port write memory. The block accepts a new request only after it
// has finished the previous one. A successful pop scans all N stored entries
// in turn through the one memory read port, then closes the gap left by slot k
// by moving each later entry down one slot. Ties go to the earliest inserted
// entry. A response waits in an output register; the block holds the next
// finished item only if that register is still occupied.
module double_ended_priority_queue_top #(
  parameter int DEPTH = depq_pkg::DEPTH_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  depq_req_if.sink  req_i,
  depq_rsp_if.source rsp_o
);
  import depq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  depq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  depq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .command_i      (req_i.command),
    .client_id_i    (req_i.client_id),
    .priority_req_i (req_i.priority_req),
    .rsp_status_o   (rsp_o.status),
    .served_id_o    (rsp_o.served_id)
  );

endmodule

`default_nettype wire

// ----- design/depq_datapath.sv -----
// Entry memories, occupancy count, scan and shift datapath, and response register.
`timescale 1ns / 1ps
`default_nettype none

module depq_datapath #(
  parameter int DEPTH = depq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire depq_pkg::ctrl_cmd_t           cmd_i,
  output depq_pkg::dp_status_t               status_o,
  input  wire logic [depq_pkg::CMD_W-1:0]    command_i,
  input  wire logic [depq_pkg::ID_W-1:0]     client_id_i,
  input  wire logic [depq_pkg::PRI_W-1:0]    priority_req_i,
  output logic      [depq_pkg::STATUS_W-1:0] rsp_status_o,
  output logic      [depq_pkg::ID_W-1:0]     served_id_o
);
  import depq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [PRI_W-1:0] prio_mem [DEPTH];
  logic [ID_W-1:0]  client_mem [DEPTH];

  logic [CMD_W-1:0]    req_cmd_q;
  logic [ID_W-1:0]     req_id_q;
  logic [PRI_W-1:0]    req_pri_q;
  logic [CW-1:0]       count_q;
  logic [AW-1:0]       idx_q;
  logic [AW-1:0]       j_q;
  logic [AW-1:0]       best_idx_q;
  logic [PRI_W-1:0]    best_pri_q;
  logic [ID_W-1:0]     best_id_q;
  logic [PRI_W-1:0]    rd_pri_q;
  logic [ID_W-1:0]     rd_id_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [ID_W-1:0]     res_id_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ID_W-1:0]     out_id_q;

  logic            want_high;
  logic            take;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [PRI_W-1:0] wr_pri;
  logic [ID_W-1:0]  wr_id;
  logic [AW-1:0]   j_plus;

  assign want_high = (req_cmd_q == CMD_POP_HIGH);
  assign take = (idx_q == '0) ||
                (want_high ? (rd_pri_q > best_pri_q) : (rd_pri_q < best_pri_q));
  assign j_plus = j_q + AW'(1);

  assign status_o.is_insert  = (req_cmd_q == CMD_INSERT);
  assign status_o.is_pop     = (req_cmd_q == CMD_POP_HIGH) || (req_cmd_q == CMD_POP_LOW);
  assign status_o.is_empty   = (count_q == '0);
  assign status_o.is_full    = (count_q == CW'(DEPTH));
  assign status_o.scan_last  = ((CW'(idx_q) + CW'(1)) == count_q);
  assign status_o.shift_more = ((CW'(j_q) + CW'(1)) < count_q);

  always_comb begin
    rd_en   = cmd_i.scan_rd | cmd_i.shift_rd;
    rd_addr = cmd_i.shift_rd ? j_plus : idx_q;
    wr_en   = cmd_i.do_insert | cmd_i.shift_wr;
    wr_addr = cmd_i.shift_wr ? j_q : count_q[AW-1:0];
    wr_pri  = cmd_i.shift_wr ? rd_pri_q : req_pri_q;
    wr_id   = cmd_i.shift_wr ? rd_id_q : req_id_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prio_mem[wr_addr]   <= wr_pri;
      client_mem[wr_addr] <= wr_id;
    end
    if (rd_en) begin
      rd_pri_q <= prio_mem[rd_addr];
      rd_id_q  <= client_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_cmd_q <= command_i;
      req_id_q  <= client_id_i;
      req_pri_q <= priority_req_i;
    end
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.scan_cmp) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.scan_cmp) begin
      j_q <= take ? idx_q : best_idx_q;
      if (take) begin
        best_idx_q <= idx_q;
        best_pri_q <= rd_pri_q;
        best_id_q  <= rd_id_q;
      end
    end else if (cmd_i.shift_wr) begin
      j_q <= j_plus;
    end
    if (cmd_i.do_insert || cmd_i.set_ok) begin
      res_status_q <= STATUS_OK;
      res_id_q     <= '0;
    end else if (cmd_i.set_full) begin
      res_status_q <= STATUS_FULL;
      res_id_q     <= '0;
    end else if (cmd_i.set_empty) begin
      res_status_q <= STATUS_EMPTY;
      res_id_q     <= '0;
    end else if (cmd_i.pop_finish) begin
      res_status_q <= STATUS_OK;
      res_id_q     <= best_id_q;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.do_insert) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.pop_finish) begin
      count_q <= count_q - CW'(1);
    end
  end

  assign rsp_status_o = out_status_q;
  assign served_id_o  = out_id_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_insert |-> (count_q < CW'(DEPTH)))
    else $error("insert into a full store");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_finish || cmd_i.shift_wr) |-> (count_q != '0) &&
      (CW'(best_idx_q) < count_q))
    else $error("removal from an empty store or beyond the count");
`endif

endmodule

`default_nettype wire

// ----- design/depq_ctrl.sv -----
// Controller state machine sequencing decode, scan, shift and response hand-off.
`timescale 1ns / 1ps
`default_nettype none

module depq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  output logic                      rsp_valid_o,
  input  wire logic                 rsp_ready_i,
  input  wire depq_pkg::dp_status_t status_i,
  output depq_pkg::ctrl_cmd_t       cmd_o
);
  import depq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DECODE    = 7'b0000010,
    S_SCAN_RD   = 7'b0000100,
    S_SCAN_CMP  = 7'b0001000,
    S_SHIFT_CHK = 7'b0010000,
    S_SHIFT_RD  = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.is_insert) begin
          if (status_i.is_full) begin
            cmd_o.set_full = 1'b1;
          end else begin
            cmd_o.do_insert = 1'b1;
          end
          state_d = S_DONE;
        end else if (status_i.is_pop) begin
          if (status_i.is_empty) begin
            cmd_o.set_empty = 1'b1;
            state_d         = S_DONE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else begin
          cmd_o.set_ok = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = status_i.scan_last ? S_SHIFT_CHK : S_SCAN_RD;
      end
      S_SHIFT_CHK: begin
        if (status_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_RD;
        end else begin
          cmd_o.pop_finish = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_CHK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished item not moved to the output register");
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CMP) |-> $past(state_q == S_SCAN_RD))
    else $error("compare without a preceding read");
  a_wr_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_RD) |-> $past(state_q == S_SHIFT_CHK && status_i.shift_more))
    else $error("shift step without a pending entry");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_double_ended_priority_queue_top.sv -----
// Self-checking testbench for the double-ended priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_double_ended_priority_queue_top;
  import depq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 400;
  localparam int N_ROWS = 22;

  typedef struct packed {
    logic [ID_W-1:0]  client;
    logic [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     served_id;
  } reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     id;
    logic [PRI_W-1:0]    prio;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [ID_W-1:0]     sid;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  depq_req_if req ();
  depq_rsp_if rsp ();

  double_ended_priority_queue_top #(.DEPTH(DEPTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // typed expectation travels alongside the request payload
  logic                row_typed;
  logic [STATUS_W-1:0] row_status;
  logic [ID_W-1:0]     row_served;

  entry_t shadow_store[$];
  reply_t awaited_replies[$];

  int err_count = 0;
  int idle_cycles = 0;
  int fill_level = 0;
  int driven_real = 0;
  int n_insert = 0, n_full = 0, n_pop = 0, n_empty = 0, n_spare = 0;
  int n_checked = 0, peak_level = 0;

  stim_row_t directed_rows [0:N_ROWS-1] = '{
    '{CMD_POP_HIGH, 16'h0000, 32'h0000_0000, 1'b1, STATUS_EMPTY, 16'h0000},
    '{CMD_POP_LOW,  16'h0000, 32'h0000_0000, 1'b1, STATUS_EMPTY, 16'h0000},
    '{CMD_SPARE,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_INSERT,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_INSERT,   16'h0000, 32'h0000_0000, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_INSERT,   16'h1234, 32'h0000_0000, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_INSERT,   16'h5678, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_SPARE,    16'h0000, 32'h0000_0000, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_POP_HIGH, 16'h0000, 32'h0000_0000, 1'b1, STATUS_OK,    16'hFFFF},
    '{CMD_POP_LOW,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_POP_LOW,  16'h0000, 32'h0000_0000, 1'b1, STATUS_OK,    16'h1234},
    '{CMD_POP_HIGH, 16'h0000, 32'h0000_0000, 1'b1, STATUS_OK,    16'h5678},
    '{CMD_POP_LOW,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, STATUS_EMPTY, 16'h0000},
    '{CMD_INSERT,   16'hAAAA, 32'h8000_0000, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_INSERT,   16'h5555, 32'h7FFF_FFFF, 1'b1, STATUS_OK,    16'h0000},
    '{CMD_INSERT,   16'h0001, 32'h0000_0001, 1'b0, STATUS_OK,    16'h0000},
    '{CMD_INSERT,   16'h8000, 32'hFFFF_FFFE, 1'b0, STATUS_OK,    16'h0000},
    '{CMD_POP_HIGH, 16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,    16'h0000},
    '{CMD_POP_LOW,  16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,    16'h0000},
    '{CMD_POP_HIGH, 16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,    16'h0000},
    '{CMD_POP_HIGH, 16'h0000, 32'h0000_0000, 1'b0, STATUS_OK,    16'h0000},
    '{CMD_POP_HIGH, 16'h0000, 32'h0000_0000, 1'b1, STATUS_EMPTY, 16'h0000}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic reply_t serve_request(input logic [CMD_W-1:0] cmd,
                                           input logic [ID_W-1:0] id,
                                           input logic [PRI_W-1:0] prio);
    reply_t r;
    entry_t e;
    int pick;
    r.status = STATUS_OK;
    r.served_id = '0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_store.size() >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          e.client = id;
          e.prio = prio;
          shadow_store.push_back(e);
        end
      end
      CMD_POP_HIGH, CMD_POP_LOW: begin
        if (shadow_store.size() == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          pick = 0;
          for (int i = 1; i < shadow_store.size(); i++) begin
            if (cmd == CMD_POP_HIGH ? shadow_store[i].prio > shadow_store[pick].prio
                                    : shadow_store[i].prio < shadow_store[pick].prio)
              pick = i;
          end
          r.served_id = shadow_store[pick].client;
          shadow_store.delete(pick);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %0s: got %0h, expected %0h (response %0d)",
             $realtime, field, got, want, n_checked);
    err_count++;
  endtask

  always @(posedge clk_i) begin : monitor
    reply_t want;
    reply_t got;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        want = serve_request(req.command, req.client_id, req.priority_req);
        case (req.command)
          CMD_INSERT: begin
            n_insert++;
            if (want.status == STATUS_FULL) n_full++;
          end
          CMD_POP_HIGH, CMD_POP_LOW: begin
            n_pop++;
            if (want.status == STATUS_EMPTY) n_empty++;
          end
          default: n_spare++;
        endcase
        if (shadow_store.size() > peak_level) peak_level = shadow_store.size();
        if (row_typed) begin
          want.status = row_status;
          want.served_id = row_served;
        end
        awaited_replies.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.served_id = rsp.served_id;
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected response", 32'(got), '0);
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.served_id !== want.served_id)
            report_mismatch("served_id", 32'(got.served_id), 32'(want.served_id));
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
      $display("tb_double_ended_priority_queue_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_item(input stim_row_t row, input bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.command      <= row.cmd;
    req.client_id    <= row.id;
    req.priority_req <= row.prio;
    row_typed        <= row.typed;
    row_status       <= row.st;
    row_served       <= row.sid;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    case (row.cmd)
      CMD_INSERT: if (fill_level < DEPTH) fill_level++;
      CMD_POP_HIGH, CMD_POP_LOW: if (fill_level > 0) fill_level--;
      default: ;
    endcase
    if (row.cmd != CMD_SPARE) driven_real++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic stim_row_t make_item(input logic [CMD_W-1:0] cmd, input int prio_mode);
    stim_row_t row;
    row.cmd = cmd;
    row.id = 16'($urandom_range(0, 16'hFFFF));
    case (prio_mode)
      0: row.prio = $urandom;
      1: row.prio = $urandom_range(0, 7);
      default: begin
        case ($urandom_range(0, 3))
          0: row.prio = 32'h0000_0000;
          1: row.prio = 32'hFFFF_FFFF;
          2: row.prio = 32'h7FFF_FFFF;
          default: row.prio = 32'h8000_0000;
        endcase
      end
    endcase
    row.typed = 1'b0;
    row.st = STATUS_OK;
    row.sid = '0;
    return row;
  endfunction

  function automatic logic [CMD_W-1:0] pick_pop();
    return $urandom_range(0, 1) ? CMD_POP_HIGH : CMD_POP_LOW;
  endfunction

  initial begin : receiver
    int stall;
    int stretch_left;
    bit calm;
    stretch_left = 0;
    calm = 1'b0;
    rsp.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(5, 40);
        calm = ($urandom_range(0, 2) == 0);
      end
      stretch_left--;
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
    end
  end

  initial begin : sender
    int seg;
    int kind;
    int count;
    int prio_mode;
    int ins_pct;
    int roll;
    bit quiet;
    logic [CMD_W-1:0] cmd;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.command = CMD_INSERT;
    req.client_id = '0;
    req.priority_req = '0;
    row_typed = 1'b0;
    row_status = STATUS_OK;
    row_served = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_ROWS; i++) put_item(directed_rows[i], 1'($urandom_range(0, 1)));
    wait_drained();

    seg = 0;
    while (driven_real < RANDOM_ITEMS + N_ROWS) begin
      kind = (seg == 0) ? 0 : (seg == 1) ? 1 : $urandom_range(0, 9);
      quiet = ($urandom_range(0, 3) == 0);
      prio_mode = $urandom_range(0, 2);
      case (kind)
        0, 1: begin
          if (kind == 0 || seg == 0) begin
            count = DEPTH - fill_level + $urandom_range(1, 4);
            for (int i = 0; i < count; i++) put_item(make_item(CMD_INSERT, prio_mode), quiet);
          end else begin
            count = fill_level + $urandom_range(1, 3);
            for (int i = 0; i < count; i++) put_item(make_item(pick_pop(), prio_mode), quiet);
          end
        end
        2: begin
          count = fill_level + $urandom_range(1, 3);
          for (int i = 0; i < count; i++) put_item(make_item(pick_pop(), prio_mode), quiet);
        end
        default: begin
          count = $urandom_range(20, 60);
          case ($urandom_range(0, 2))
            0: ins_pct = 25;
            1: ins_pct = 50;
            default: ins_pct = 72;
          endcase
          for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) cmd = CMD_SPARE;
            else if (roll < 3 + ins_pct) cmd = CMD_INSERT;
            else cmd = pick_pop();
            put_item(make_item(cmd, prio_mode), quiet);
          end
        end
      endcase
      if ($urandom_range(0, 3) == 0) wait_drained();
      seg++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts (%0d refused as full), %0d pops (%0d on empty), %0d spare",
             n_insert, n_full, n_pop, n_empty, n_spare);
    $display("checked %0d responses, peak occupancy %0d of %0d, %0d mismatches",
             n_checked, peak_level, DEPTH, err_count);
    if (err_count == 0 && awaited_replies.size() == 0) begin
      $display("tb_double_ended_priority_queue_top: clean");
    end else begin
      $display("tb_double_ended_priority_queue_top: errors");
    end
    $finish;
  end

endmodule
